[sv/bdsam_pkg.sv]
// Shared types and constants for the bus decoder with SAM control.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bdsam_pkg;

    localparam int ADDR_W    = 16;
    localparam int OP_W      = 2;
    localparam int PHASE_W   = 4;
    localparam int CYCLES_W  = 5;
    localparam int REG_IDX_W = 2;

    // Stream widths: payload fields packed from bit 0; tdata padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    // Length of the video window that write flushes are checked against.
    localparam int VIDEO_WINDOW_BYTES = 6144;

    // Address map boundaries.
    localparam logic [ADDR_W-1:0] VECTOR_START  = 16'hFFF2;
    localparam logic [ADDR_W-1:0] VECTOR_OFFSET = 16'h4000;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_NODATA = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        TGT_RAM       = 3'd0,
        TGT_ROM       = 3'd1,
        TGT_PIA0      = 3'd2,
        TGT_PIA1      = 3'd3,
        TGT_SAM       = 3'd4,
        TGT_VECTOR    = 3'd5,
        TGT_UNMAPPED  = 3'd6,
        TGT_UNHANDLED = 3'd7
    } target_t;

    typedef enum logic [1:0] {
        SPEED_HALF     = 2'd0,
        SPEED_HALF_RAM = 2'd1,
        SPEED_FULL     = 2'd2,
        SPEED_FULL_ALT = 2'd3
    } speed_t;

    // One bus access.
    typedef struct packed {
        logic [ADDR_W-1:0]  bus_address;
        op_t                operation;
        logic [PHASE_W-1:0] phase_cycles;
    } access_t;

    // SAM control bits, packed so that bit n of the struct is SAM bit n.
    typedef struct packed {
        logic       all_ram;
        logic [1:0] size;
        speed_t     speed;
        logic       page;
        logic [6:0] video_base;
        logic [2:0] mode;
    } sam_state_t;

    // Decode of one access, before the SAM fields are attached.
    typedef struct packed {
        target_t               target;
        logic [ADDR_W-1:0]     memory_address;
        logic [REG_IDX_W-1:0]  register_index;
        logic [CYCLES_W-1:0]   total_cycles;
        logic                  video_flush;
    } decode_t;

endpackage

`default_nettype wire

[sv/bdsam_map.sv]
// Address decode, wait-cycle count and video flush check for one access.
// Purely combinational; uses types from bdsam_pkg.
`default_nettype none

module bdsam_map #(
    parameter int VIDEO_WINDOW_BYTES = bdsam_pkg::VIDEO_WINDOW_BYTES
) (
    input  wire bdsam_pkg::access_t    access,
    input  wire bdsam_pkg::sam_state_t sam_state,
    output bdsam_pkg::decode_t         decode
);

    logic [bdsam_pkg::ADDR_W-1:0]   addr;
    logic                           has_data;
    logic                           wr_access;
    logic                           io_page;
    logic [bdsam_pkg::PHASE_W-1:0]  wait_cycles;
    logic [bdsam_pkg::ADDR_W:0]     win_start;
    logic [bdsam_pkg::ADDR_W:0]     win_end;
    logic                           in_window;

    assign addr      = access.bus_address;
    assign has_data  = (access.operation == bdsam_pkg::OP_READ) ||
                       (access.operation == bdsam_pkg::OP_WRITE);
    assign wr_access = (access.operation == bdsam_pkg::OP_WRITE);
    assign io_page   = (addr[15:8] == 8'hFF);

    // The window is not wrapped: its end is kept one bit wider than an address.
    assign win_start = {1'b0, sam_state.video_base, 9'd0};
    assign win_end   = win_start + (bdsam_pkg::ADDR_W+1)'(VIDEO_WINDOW_BYTES);
    assign in_window = ({1'b0, addr} >= win_start) && ({1'b0, addr} < win_end);

    always_comb begin
        wait_cycles = '0;
        case (sam_state.speed)
            bdsam_pkg::SPEED_HALF: begin
                wait_cycles = access.phase_cycles;
            end
            bdsam_pkg::SPEED_HALF_RAM: begin
                if (has_data && (!addr[15] || sam_state.all_ram)) begin
                    wait_cycles = access.phase_cycles;
                end
            end
            default: begin
                wait_cycles = '0;
            end
        endcase
    end

    always_comb begin
        decode.target         = bdsam_pkg::TGT_UNHANDLED;
        decode.memory_address = '0;
        decode.register_index = '0;
        decode.video_flush    = 1'b0;
        decode.total_cycles   = {1'b0, access.phase_cycles} + {1'b0, wait_cycles};

        if (io_page) begin
            if (addr[7:5] == 3'b000) begin
                decode.target         = bdsam_pkg::TGT_PIA0;
                decode.register_index = addr[1:0];
            end else if (addr[7:5] == 3'b001) begin
                decode.target         = bdsam_pkg::TGT_PIA1;
                decode.register_index = addr[1:0];
            end else if (addr[7:5] == 3'b110) begin
                decode.target = bdsam_pkg::TGT_SAM;
            end else if (addr >= bdsam_pkg::VECTOR_START) begin
                decode.target         = bdsam_pkg::TGT_VECTOR;
                decode.memory_address = addr - bdsam_pkg::VECTOR_OFFSET;
            end else begin
                decode.target = bdsam_pkg::TGT_UNHANDLED;
            end
        end else begin
            if (!addr[15]) begin
                decode.target         = bdsam_pkg::TGT_RAM;
                decode.memory_address = addr;
            end else if (addr[15:13] == 3'b101) begin
                decode.target         = bdsam_pkg::TGT_ROM;
                decode.memory_address = addr;
            end else begin
                decode.target = bdsam_pkg::TGT_UNMAPPED;
            end
            decode.video_flush = wr_access && in_window;
        end
    end

endmodule

`default_nettype wire

[sv/bdsam_ctrl.sv]
// SAM control register: holds the sixteen SAM bits and applies set/clear accesses.
// Uses types from bdsam_pkg.
`default_nettype none

module bdsam_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         update_en,
    input  wire bdsam_pkg::access_t     access,
    output bdsam_pkg::sam_state_t       sam_state,
    output bdsam_pkg::sam_state_t       sam_state_after
);

    bdsam_pkg::sam_state_t sam_reg;
    bdsam_pkg::sam_state_t sam_next;
    logic [15:0]           sam_bits;
    logic                  sam_hit;
    logic                  has_data;

    assign has_data = (access.operation == bdsam_pkg::OP_READ) ||
                      (access.operation == bdsam_pkg::OP_WRITE);
    // 0xFFC0-0xFFDF: address bits 4..1 pick the bit, bit 0 is its new value.
    assign sam_hit  = (access.bus_address[15:5] == 11'h7FE) && has_data;

    always_comb begin
        sam_bits = 16'(sam_reg);
        if (sam_hit) begin
            sam_bits[access.bus_address[4:1]] = access.bus_address[0];
        end
        sam_next = bdsam_pkg::sam_state_t'(sam_bits);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sam_reg <= '0;
        end else if (update_en) begin
            sam_reg <= sam_next;
        end
    end

    assign sam_state       = sam_reg;
    assign sam_state_after = sam_next;

endmodule

`default_nettype wire

[sv/bus_decoder_with_sam_control.sv]
// Top level of the bus decoder with SAM control: input register, decode, result register.
// Instantiates bdsam_map and bdsam_ctrl; uses bdsam_pkg.
//
//  Channel   Direction  tdata / tuser contents
//  s_axis    in         tdata: bus_address, phase_cycles; tuser: operation
//  m_axis    out        tdata: memory_address .. ram_size; tuser: target
//
// An item is decoded in the cycle after it is taken into the input register and
// is then captured in the result register that drives m_axis; one item can be
// accepted every cycle while m_axis does not stall. The SAM bits change as an
// item leaves the input register, so each result reports the state left by its own access.
// Reset clears both valid flags and the SAM bits. A stall on m_axis holds the
// result and, once the input register is full too, drops s_axis_tready.
`default_nettype none

module bus_decoder_with_sam_control #(
    parameter int VIDEO_WINDOW_BYTES = bdsam_pkg::VIDEO_WINDOW_BYTES
) (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] bus_address, [19:16] phase_cycles, [23:20] zero
    input  wire [bdsam_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  wire [bdsam_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [15:0] memory_address, [17:16] register_index, [22:18] total_cycles,
    // [23] video_flush, [26:24] graphics_mode, [42:27] graphics_base,
    // [44:43] speed_mode, [45] all_ram_mode, [46] page_one, [48:47] ram_size,
    // [55:49] zero
    output logic [bdsam_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [2:0] target
    output logic [bdsam_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    logic                   in_valid_reg;
    bdsam_pkg::access_t     in_item_reg;
    logic                   out_valid_reg;
    logic [bdsam_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [bdsam_pkg::M_TDATA_W-1:0] out_data_next;
    logic [bdsam_pkg::M_TUSER_W-1:0] out_user_reg;

    logic                   stage_fire;
    logic                   in_take;
    bdsam_pkg::sam_state_t  sam_state;
    bdsam_pkg::sam_state_t  sam_after;
    bdsam_pkg::decode_t     decode;

    assign stage_fire    = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || stage_fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bdsam_map #(
        .VIDEO_WINDOW_BYTES (VIDEO_WINDOW_BYTES)
    ) u_map (
        .access    (in_item_reg),
        .sam_state (sam_state),
        .decode    (decode)
    );

    bdsam_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .update_en       (stage_fire),
        .access          (in_item_reg),
        .sam_state       (sam_state),
        .sam_state_after (sam_after)
    );

    assign out_data_next = {
        7'd0,
        sam_after.size,
        sam_after.page,
        sam_after.all_ram,
        sam_after.speed,
        sam_after.video_base, 9'd0,
        sam_after.mode,
        decode.video_flush,
        decode.total_cycles,
        decode.register_index,
        decode.memory_address
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (stage_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (stage_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.bus_address  <= s_axis_tdata[15:0];
            in_item_reg.phase_cycles <= s_axis_tdata[19:16];
            in_item_reg.operation    <= bdsam_pkg::op_t'(s_axis_tuser);
        end
        if (stage_fire) begin
            out_data_reg <= out_data_next;
            out_user_reg <= decode.target;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

[sv/bdsam_checker.sv]
// Port-level checks for bus_decoder_with_sam_control, bound to the top level.
// Uses constants and codes from bdsam_pkg.
`default_nettype none

module bdsam_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [bdsam_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire [bdsam_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    // A held result must not change while the sink stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Synchronous reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A register index is only reported for the two PIAs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != bdsam_pkg::TGT_PIA0) &&
        (m_axis_tuser != bdsam_pkg::TGT_PIA1) |-> m_axis_tdata[17:16] == 2'd0)
        else $error("register index outside PIA space");

    // Page 0xFF accesses never flush the video window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[23] |->
        (m_axis_tuser == bdsam_pkg::TGT_RAM) || (m_axis_tuser == bdsam_pkg::TGT_ROM) ||
        (m_axis_tuser == bdsam_pkg::TGT_UNMAPPED))
        else $error("video flush from I/O page");

endmodule

bind bus_decoder_with_sam_control bdsam_checker u_bdsam_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for bus_decoder_with_sam_control.
// Drives bus accesses on s_axis, predicts each decode and SAM update, and checks m_axis.
// Depends on bdsam_pkg and the block's top level only.
`default_nettype none

module tb;
    import bdsam_pkg::*;

    localparam int RANDOM_ACCESSES = 1900;
    localparam int DRAIN_LIMIT     = 2000;

    typedef struct {
        target_t     target;
        logic [15:0] mem_addr;
        logic [1:0]  reg_sel;
        logic [4:0]  cycles;
        logic        flush;
        logic [2:0]  mode;
        logic [15:0] gfx_base;
        speed_t      speed;
        logic        all_ram;
        logic        page;
        logic [1:0]  size;
    } bus_result_t;

    typedef struct {
        access_t     acc;
        bit          known;
        bus_result_t want;
    } access_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [S_TUSER_W-1:0] s_user = '0;
    logic m_ready = 1'b0;

    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // Model of the SAM control bits.
    logic [2:0] sam_mode = '0;
    logic [6:0] sam_vbase = '0;
    logic [1:0] sam_speed = '0;
    logic       sam_all_ram = 1'b0;
    logic       sam_page = 1'b0;
    logic [1:0] sam_size = '0;

    bus_result_t pending_decodes[$];
    int unsigned error_count = 0;
    bit sender_calm = 1'b0;
    bit reader_calm = 1'b0;

    always #5 aclk = ~aclk;

    bus_decoder_with_sam_control dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Decodes one access against the modeled SAM state and applies any SAM bit change.
    function automatic bus_result_t decode_access(access_t acc);
        bus_result_t r;
        logic [15:0] a;
        logic        data_cycle;
        logic [4:0]  extra;
        logic [3:0]  sel;
        int unsigned win_lo;
        a = acc.bus_address;
        data_cycle = (acc.operation == OP_READ) || (acc.operation == OP_WRITE);
        extra = '0;
        // The slow-down comes from the speed mode held before this access.
        if (sam_speed == SPEED_HALF) begin
            extra = {1'b0, acc.phase_cycles};
        end else if (sam_speed == SPEED_HALF_RAM && data_cycle
                     && (a < 16'h8000 || sam_all_ram)) begin
            extra = {1'b0, acc.phase_cycles};
        end
        r.mem_addr = '0;
        r.reg_sel = '0;
        r.flush = 1'b0;
        if (a[15:8] == 8'hFF) begin
            if (a[7:0] < 8'h20) begin
                r.target = TGT_PIA0;
                r.reg_sel = a[1:0];
            end else if (a[7:0] < 8'h40) begin
                r.target = TGT_PIA1;
                r.reg_sel = a[1:0];
            end else if (a[7:5] == 3'b110) begin
                r.target = TGT_SAM;
                if (data_cycle) begin
                    sel = a[4:1];
                    if (sel <= 2) begin
                        sam_mode[sel[1:0]] = a[0];
                    end else if (sel <= 9) begin
                        sam_vbase[3'(sel - 4'd3)] = a[0];
                    end else if (sel == 10) begin
                        sam_page = a[0];
                    end else if (sel <= 12) begin
                        sam_speed[1'(sel - 4'd11)] = a[0];
                    end else if (sel <= 14) begin
                        sam_size[1'(sel - 4'd13)] = a[0];
                    end else begin
                        sam_all_ram = a[0];
                    end
                end
            end else if (a >= VECTOR_START) begin
                r.target = TGT_VECTOR;
                r.mem_addr = a - VECTOR_OFFSET;
            end else begin
                r.target = TGT_UNHANDLED;
            end
        end else begin
            if (a < 16'h8000) begin
                r.target = TGT_RAM;
                r.mem_addr = a;
            end else if (a >= 16'hA000 && a < 16'hC000) begin
                r.target = TGT_ROM;
                r.mem_addr = a;
            end else begin
                r.target = TGT_UNMAPPED;
            end
            // The window is not wrapped, so near the top it runs off the address space.
            if (acc.operation == OP_WRITE) begin
                win_lo = sam_vbase * 512;
                r.flush = (a >= win_lo) && (a < win_lo + VIDEO_WINDOW_BYTES);
            end
        end
        r.cycles = {1'b0, acc.phase_cycles} + extra;
        r.mode = sam_mode;
        r.gfx_base = {sam_vbase, 9'b0};
        r.speed = speed_t'(sam_speed);
        r.all_ram = sam_all_ram;
        r.page = sam_page;
        r.size = sam_size;
        return r;
    endfunction

    function automatic access_row_t row(logic [15:0] a, op_t op, logic [3:0] ph);
        access_row_t x;
        x.acc.bus_address = a;
        x.acc.operation = op;
        x.acc.phase_cycles = ph;
        x.known = 1'b0;
        x.want = '{TGT_RAM, 16'h0, 2'd0, 5'd0, 1'b0, 3'd0, 16'h0, SPEED_HALF, 1'b0, 1'b0, 2'd0};
        return x;
    endfunction

    // A row taken with the SAM still in its reset state, so all mode fields read zero.
    function automatic access_row_t row_known(logic [15:0] a, op_t op, logic [3:0] ph,
                                              target_t t, logic [15:0] ma, logic [1:0] ri,
                                              logic [4:0] cyc, logic fl);
        access_row_t x;
        x = row(a, op, ph);
        x.known = 1'b1;
        x.want.target = t;
        x.want.mem_addr = ma;
        x.want.reg_sel = ri;
        x.want.cycles = cyc;
        x.want.flush = fl;
        return x;
    endfunction

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic access_t random_access();
        access_t acc;
        logic [15:0] start;
        int unsigned pick;
        start = {sam_vbase, 9'b0};
        case ($urandom_range(0, 9))
            0: acc.bus_address = 16'($urandom_range(0, 16'hFFFF));
            1: acc.bus_address = 16'($urandom_range(0, 16'h7FFF));
            2: acc.bus_address = 16'($urandom_range(16'h8000, 16'hFEFF));
            3: acc.bus_address = 16'hFF00 | 16'($urandom_range(0, 16'h3F));
            4, 5: acc.bus_address = 16'hFFC0 | 16'($urandom_range(0, 16'h1F));
            6: acc.bus_address = 16'hFF00 | 16'($urandom_range(0, 16'hFF));
            7: acc.bus_address = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            default: begin
                // Land on or next to the edges of the current video window.
                pick = $urandom_range(0, 6);
                case (pick)
                    0: acc.bus_address = start - 16'd1;
                    1: acc.bus_address = start;
                    2: acc.bus_address = start + 16'd1;
                    3: acc.bus_address = start + 16'(VIDEO_WINDOW_BYTES - 1);
                    4: acc.bus_address = start + 16'(VIDEO_WINDOW_BYTES);
                    5: acc.bus_address = start + 16'(VIDEO_WINDOW_BYTES + 1);
                    default: acc.bus_address =
                        start + 16'($urandom_range(0, VIDEO_WINDOW_BYTES - 1));
                endcase
            end
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            acc.operation = OP_READ;
        end else if (pick < 8) begin
            acc.operation = OP_WRITE;
        end else if (pick == 8) begin
            acc.operation = OP_NODATA;
        end else begin
            acc.operation = OP_SPARE;
        end
        acc.phase_cycles = 4'($urandom_range(0, 15));
        return acc;
    endfunction

    task automatic send_access(access_row_t r);
        int unsigned gap;
        bus_result_t predicted;
        gap = draw_wait(sender_calm);
        if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {{(S_TDATA_W - 20){1'b0}}, r.acc.phase_cycles, r.acc.bus_address};
        s_user <= r.acc.operation;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = decode_access(r.acc);
        pending_decodes.push_back(r.known ? r.want : predicted);
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic check_result();
        bus_result_t want;
        logic [M_TDATA_W-1:0] d;
        d = m_axis_tdata;
        if (pending_decodes.size() == 0) begin
            report_error("result item arrived with no access outstanding");
            return;
        end
        want = pending_decodes.pop_front();
        compare_field("target", 16'(m_axis_tuser), 16'(want.target));
        compare_field("memory_address", d[15:0], want.mem_addr);
        compare_field("register_index", 16'(d[17:16]), 16'(want.reg_sel));
        compare_field("total_cycles", 16'(d[22:18]), 16'(want.cycles));
        compare_field("video_flush", 16'(d[23]), 16'(want.flush));
        compare_field("graphics_mode", 16'(d[26:24]), 16'(want.mode));
        compare_field("graphics_base", d[42:27], want.gfx_base);
        compare_field("speed_mode", 16'(d[44:43]), 16'(want.speed));
        compare_field("all_ram_mode", 16'(d[45]), 16'(want.all_ram));
        compare_field("page_one", 16'(d[46]), 16'(want.page));
        compare_field("ram_size", 16'(d[48:47]), 16'(want.size));
        compare_field("tdata padding", 16'(d[M_TDATA_W-1:49]), 16'd0);
    endtask

    // Result side: random stalls before each item, with calm stretches.
    initial begin
        int unsigned stall;
        wait (aresetn);
        forever begin
            stall = draw_wait(reader_calm);
            if ($urandom_range(0, 29) == 0) reader_calm = !reader_calm;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            check_result();
        end
    end

    initial begin
        access_row_t rows[$];
        access_row_t r;
        int unsigned waited;
        rows.push_back(row_known(16'h0000, OP_READ,   4'd0,  TGT_RAM, 16'h0000, 2'd0, 5'd0, 1'b0));
        rows.push_back(row_known(16'h7FFF, OP_WRITE,  4'd15, TGT_RAM, 16'h7FFF, 2'd0, 5'd30, 1'b0));
        rows.push_back(row_known(16'h17FF, OP_WRITE,  4'd1,  TGT_RAM, 16'h17FF, 2'd0, 5'd2, 1'b1));
        rows.push_back(row_known(16'h1800, OP_WRITE,  4'd1,  TGT_RAM, 16'h1800, 2'd0, 5'd2, 1'b0));
        rows.push_back(row_known(16'hA000, OP_READ,   4'd3,  TGT_ROM, 16'hA000, 2'd0, 5'd6, 1'b0));
        rows.push_back(row_known(16'hBFFF, OP_WRITE,  4'd2,  TGT_ROM, 16'hBFFF, 2'd0, 5'd4, 1'b0));
        rows.push_back(row_known(16'h8000, OP_READ,   4'd1,  TGT_UNMAPPED, 16'h0, 2'd0, 5'd2, 1'b0));
        rows.push_back(row_known(16'hFEFF, OP_NODATA, 4'd4,  TGT_UNMAPPED, 16'h0, 2'd0, 5'd8, 1'b0));
        rows.push_back(row_known(16'hFF03, OP_READ,   4'd1,  TGT_PIA0, 16'h0, 2'd3, 5'd2, 1'b0));
        rows.push_back(row_known(16'hFF3D, OP_WRITE,  4'd1,  TGT_PIA1, 16'h0, 2'd1, 5'd2, 1'b0));
        rows.push_back(row_known(16'hFFF2, OP_READ,   4'd1,  TGT_VECTOR, 16'hBFF2, 2'd0, 5'd2, 1'b0));
        rows.push_back(row_known(16'hFFFF, OP_WRITE,  4'd0,  TGT_VECTOR, 16'hBFFF, 2'd0, 5'd0, 1'b0));
        rows.push_back(row_known(16'hFF40, OP_READ,   4'd1,  TGT_UNHANDLED, 16'h0, 2'd0, 5'd2, 1'b0));
        // Neither a spare operation code nor a no-data cycle may touch the SAM.
        rows.push_back(row_known(16'hFFC1, OP_SPARE,  4'd1,  TGT_SAM, 16'h0, 2'd0, 5'd2, 1'b0));
        rows.push_back(row_known(16'hFFDF, OP_NODATA, 4'd1,  TGT_SAM, 16'h0, 2'd0, 5'd2, 1'b0));
        // Half speed in RAM: waits only for data cycles below 0x8000 or in all-RAM mode.
        rows.push_back(row(16'hFFD7, OP_WRITE,  4'd1));
        rows.push_back(row(16'h8000, OP_READ,   4'd5));
        rows.push_back(row(16'h1000, OP_READ,   4'd5));
        rows.push_back(row(16'h1000, OP_NODATA, 4'd5));
        rows.push_back(row(16'hFFDF, OP_READ,   4'd1));
        rows.push_back(row(16'hA000, OP_READ,   4'd7));
        rows.push_back(row(16'hFFD9, OP_WRITE,  4'd15));
        // Move the video window to the top of memory, where it must not wrap.
        for (int b = 3; b <= 9; b++) rows.push_back(row(16'hFFC1 + 16'(2 * b), OP_WRITE, 4'd1));
        rows.push_back(row(16'hFE00, OP_WRITE, 4'd1));
        rows.push_back(row(16'h0000, OP_WRITE, 4'd1));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_access(rows[i]);
        repeat (RANDOM_ACCESSES) begin
            r = row(16'h0, OP_READ, 4'd0);
            r.acc = random_access();
            send_access(r);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_decodes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_decodes.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_decodes.size()));
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
